// ===== rtl/bspline_deboor_evaluator_top_macros.svh =====
// Assertion macros for the B-spline evaluator checker.
// Used by bde_chk.sv.
`ifndef BSPLINE_DEBOOR_EVALUATOR_TOP_MACROS_SVH
`define BSPLINE_DEBOOR_EVALUATOR_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define BDE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define BDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== rtl/bde_pkg.sv =====
// Package for the B-spline de Boor evaluator: command codes, widths, defaults.
// No dependencies.
`timescale 1ns / 1ps
package bde_pkg;
	localparam int MAX_POINTS_DEF = 64;
	localparam int MAX_DEGREE_DEF = 5;
	localparam int FRAC_BITS_DEF = 16;
	localparam logic [1:0] CMD_POINT = 2'd0;
	localparam logic [1:0] CMD_KNOT = 2'd1;
	localparam logic [1:0] CMD_EVAL = 2'd2;
	localparam logic CFG_DEGREE = 1'b0;
	localparam logic CFG_COUNT = 1'b1;
	localparam logic [2:0] DEGREE_RESET = 3'd3;
	localparam logic [6:0] COUNT_RESET = 7'd8;
endpackage

// ===== rtl/bspline_deboor_evaluator_top.sv =====
// Top level of the B-spline de Boor evaluator: point and knot memories,
// span search, serial divider and multiplier. Depends on bde_pkg.
`timescale 1ns / 1ps
// Usage:
//  Command channel: an item is taken when start is high and busy is low.
//   cmd 0 writes a control point to slot, cmd 1 writes a knot, cmd 2
//   evaluates the curve at time_value, cmd 3 does nothing.
//  Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
//   index 0 is the degree, index 1 the point count. Write only when idle.
//  Result: pos_x/y/z and degenerate are shown for one cycle with done high.
//   The receiver cannot stall; done is not held, pos and degenerate stay until the next result.
//  Sequence: a write does not raise busy. An evaluation reads and clamps t
//   against two knots, walks the knots one at a time to find the span, loads
//   p+1 points, and then for each of p(p+1)/2 steps reads two knots, runs a
//   restoring division of FRAC_BITS+33 quotient bits (skipped on a zero knot
//   difference) and three product/accumulate pairs, then writes the output.
//   The bit-serial divider takes most of the evaluation time. done rises in
//   the cycle busy falls, and the next item can be taken in that cycle.
//  Reset: control state clears, registers take degree 3 and count 8.
//   The memories are not cleared; entries must be written before use.
module bspline_deboor_evaluator_top
	import bde_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int MAX_DEGREE = MAX_DEGREE_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [1:0] cmd,
	input  logic [6:0] slot,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic signed [31:0] time_value,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_index,
	input  logic [6:0] cfg_data,
	output logic done,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic degenerate
);
	localparam int KDEPTH = MAX_POINTS + MAX_DEGREE + 1;
	localparam int PW = $clog2(MAX_POINTS);
	localparam int KW = $clog2(KDEPTH);
	localparam int DW = $clog2(MAX_DEGREE + 1);
	localparam int IW = KW + 1;
	localparam int QW = FRAC_BITS + 33;
	localparam logic signed [31:0] ALIM = 32'sd1 <<< 30;
	localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

	// state codes
	localparam logic [3:0] ST_IDLE = 4'd0, ST_TRD = 4'd1, ST_TCLAMP = 4'd2,
		ST_SRD = 4'd3, ST_SCHK = 4'd4, ST_PRD = 4'd5, ST_PWR = 4'd6,
		ST_KRD = 4'd7, ST_KLO = 4'd8, ST_DIV = 4'd9, ST_MUL = 4'd10,
		ST_MACC = 4'd11, ST_OUT = 4'd12, ST_TUP = 4'd13;

	logic [3:0] state_q;
	logic [2:0] deg_q;
	logic [6:0] cnt_q;

	// memories
	logic [95:0] pmem [MAX_POINTS];
	logic [31:0] kmem [KDEPTH];
	logic [PW-1:0] prd_addr;
	logic [KW-1:0] krd_addr;
	logic [95:0] prd_q;
	logic signed [31:0] krd_q;

	// evaluation registers
	logic [DW-1:0] p_q;
	logic [IW-1:0] n_q, k_q, ridx_q;
	logic [DW-1:0] r_q, i_q, li_q;
	logic signed [31:0] t_q, lo_q;
	logic signed [31:0] d_q [MAX_DEGREE+1][3];
	logic degen_q;
	logic signed [31:0] alpha_q;
	logic [QW-1:0] quo_q, nmag_q;
	logic [QW:0] rem_q;
	logic [32:0] dmag_q;
	logic neg_q;
	logic [6:0] dcnt_q;
	logic [1:0] c_q;
	logic signed [63:0] prod_q;
	logic done_q;
	logic signed [31:0] ox_q, oy_q, oz_q;
	logic odeg_q;

	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done = done_q;
	assign pos_x = ox_q;
	assign pos_y = oy_q;
	assign pos_z = oz_q;
	assign degenerate = odeg_q;

	// effective degree and count
	logic [DW-1:0] p_eff;
	logic [IW-1:0] n_eff;
	always_comb begin
		p_eff = (deg_q == 3'd0) ? DW'(1) :
			((32'(deg_q) > MAX_DEGREE) ? DW'(MAX_DEGREE) : DW'(deg_q));
		if (32'(cnt_q) < 32'(p_eff) + 1) n_eff = IW'(p_eff) + IW'(1);
		else if (32'(cnt_q) > MAX_POINTS) n_eff = IW'(MAX_POINTS);
		else n_eff = IW'(cnt_q);
	end

	// writes and synchronous reads
	always_ff @(posedge clk) begin
		if (start && !busy && cmd == CMD_POINT && 32'(slot) < MAX_POINTS)
			pmem[PW'(slot)] <= {coord_z, coord_y, coord_x};
		if (start && !busy && cmd == CMD_KNOT && 32'(slot) < KDEPTH)
			kmem[KW'(slot)] <= time_value;
		prd_q <= pmem[prd_addr];
		krd_q <= kmem[krd_addr];
	end
	assign prd_addr = PW'(ridx_q);
	assign krd_addr = KW'(ridx_q);

	// alpha denominator and divider shift helpers
	logic signed [63:0] den_w;
	assign den_w = 64'(krd_q) - 64'(lo_q);
	logic [QW:0] rem_sh;
	assign rem_sh = {rem_q[QW-1:0], nmag_q[QW-1]};
	logic signed [32:0] diff_w;
	assign diff_w = 33'(d_q[i_q][c_q]) - 33'(d_q[i_q - DW'(1)][c_q]);
	// alpha is within +-2^30, so the product fits 64 bits
	logic signed [64:0] mul_w;
	assign mul_w = 65'(alpha_q) * 65'(diff_w);
	logic signed [63:0] sum_w;
	assign sum_w = 64'(d_q[i_q - DW'(1)][c_q]) + (prod_q + HALF >>> FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			deg_q <= DEGREE_RESET;
			cnt_q <= COUNT_RESET;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				if (cfg_index == CFG_DEGREE) deg_q <= cfg_data[2:0];
				else cnt_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start && cmd == CMD_EVAL) begin
						p_q <= p_eff;
						n_q <= n_eff;
						t_q <= time_value;
						ridx_q <= IW'(p_eff);
						degen_q <= 1'b0;
						state_q <= ST_TRD;
					end
				end
				ST_TRD: begin
					// knot[p] is being read; next read knot[n]
					ridx_q <= n_q;
					state_q <= ST_TCLAMP;
				end
				ST_TCLAMP: begin
					// lower clamp against knot[p]
					if (t_q < krd_q) t_q <= krd_q;
					state_q <= ST_TUP;
					k_q <= IW'(p_q);
					ridx_q <= IW'(p_q) + IW'(1);
				end
				ST_TUP: begin
					// upper clamp against knot[n], wins over the lower one
					if (t_q > krd_q) t_q <= krd_q;
					state_q <= ST_SRD;
				end
				ST_SRD: begin
					state_q <= ST_SCHK;
				end
				ST_SCHK: begin
					if (k_q < n_q - IW'(1) && krd_q < t_q) begin
						k_q <= k_q + IW'(1);
						ridx_q <= k_q + IW'(2);
						state_q <= ST_SRD;
					end else begin
						li_q <= '0;
						ridx_q <= k_q - IW'(p_q);
						state_q <= ST_PRD;
					end
				end
				ST_PRD: state_q <= ST_PWR;
				ST_PWR: begin
					d_q[li_q][0] <= prd_q[31:0];
					d_q[li_q][1] <= prd_q[63:32];
					d_q[li_q][2] <= prd_q[95:64];
					if (li_q == p_q) begin
						r_q <= DW'(1);
						i_q <= p_q;
						ridx_q <= k_q;
						state_q <= ST_KRD;
					end else begin
						li_q <= li_q + DW'(1);
						ridx_q <= ridx_q + IW'(1);
						state_q <= ST_PRD;
					end
				end
				ST_KRD: begin
					// lo = knot[i+k-p] requested; hi next
					ridx_q <= IW'(i_q) + k_q + IW'(1) - IW'(r_q);
					state_q <= ST_KLO;
					c_q <= 2'd0;
				end
				ST_KLO: begin
					if (c_q == 2'd0) begin
						lo_q <= krd_q;
						c_q <= 2'd1;
					end else begin
						c_q <= 2'd0;
						if (den_w == 0) begin
							degen_q <= 1'b1;
							alpha_q <= '0;
							state_q <= ST_MUL;
						end else begin
							neg_q <= (64'(t_q) < 64'(lo_q)) ^ den_w[63];
							nmag_q <= QW'((64'(t_q) < 64'(lo_q)) ?
								(64'(lo_q) - 64'(t_q)) << FRAC_BITS :
								(64'(t_q) - 64'(lo_q)) << FRAC_BITS);
							dmag_q <= 33'(den_w[63] ? -den_w : den_w);
							rem_q <= '0;
							quo_q <= '0;
							dcnt_q <= 7'(QW);
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					// restoring division, one quotient bit per cycle
					if (dcnt_q != 0) begin
						nmag_q <= nmag_q << 1;
						if (rem_sh >= (QW+1)'(dmag_q)) begin
							rem_q <= rem_sh - (QW+1)'(dmag_q);
							quo_q <= {quo_q[QW-2:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							quo_q <= {quo_q[QW-2:0], 1'b0};
						end
						dcnt_q <= dcnt_q - 7'd1;
					end else begin
						if (quo_q > QW'(ALIM)) alpha_q <= neg_q ? -ALIM : ALIM;
						else alpha_q <= neg_q ? -32'(quo_q) : 32'(quo_q);
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q <= mul_w[63:0];
					state_q <= ST_MACC;
				end
				ST_MACC: begin
					if (sum_w > 64'sd2147483647) d_q[i_q][c_q] <= 32'h7fffffff;
					else if (sum_w < -64'sd2147483648) d_q[i_q][c_q] <= 32'h80000000;
					else d_q[i_q][c_q] <= sum_w[31:0];
					if (c_q != 2'd2) begin
						c_q <= c_q + 2'd1;
						state_q <= ST_MUL;
					end else if (i_q > r_q) begin
						i_q <= i_q - DW'(1);
						ridx_q <= IW'(i_q) - IW'(1) + k_q - IW'(p_q);
						state_q <= ST_KRD;
					end else if (r_q < p_q) begin
						r_q <= r_q + DW'(1);
						i_q <= p_q;
						ridx_q <= k_q;
						state_q <= ST_KRD;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					ox_q <= d_q[p_q][0];
					oy_q <= d_q[p_q][1];
					oz_q <= d_q[p_q][2];
					odeg_q <= degen_q;
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/bde_chk.sv =====
// Port-level checker for the B-spline evaluator, bound to the top level.
// Depends on bspline_deboor_evaluator_top_macros.svh.
`timescale 1ns / 1ps
`include "bspline_deboor_evaluator_top_macros.svh"
module bde_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic cfg_ready
);
	`BDE_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done)
	`BDE_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
	`BDE_ASSERT_NEXT(a_done_from_busy, clk, arst_n, !busy && !start, !done)
	`BDE_ASSERT_IMP(a_cfg_ready, clk, arst_n, 1'b1, cfg_ready)
endmodule

bind bspline_deboor_evaluator_top bde_chk u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .cfg_ready(cfg_ready)
);
